// ----- design/pes_header_stripper_unit_defines.svh -----
// Assertion macros used by the checker file.
`ifndef PES_HEADER_STRIPPER_UNIT_DEFINES_SVH
`define PES_HEADER_STRIPPER_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent on the next clock edge.
`define PHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Assert that a condition holds on every clock edge outside reset.
`define PHS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);
`endif

// ----- design/phs_pkg.sv -----
// Shared types and constants of the PES header stripper.
package phs_pkg;
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_START  = 2'd0;
  localparam logic [1:0] ERR_LENGTH = 2'd1;
  localparam logic [1:0] ERR_MARKER = 2'd2;
  localparam logic [1:0] ERR_HDRLEN = 2'd3;

  localparam logic [0:0] CFG_TICK_MULT   = 1'b0;
  localparam logic [0:0] CFG_DELAY_LIMIT = 1'b1;

  localparam logic [7:0] SID_PADDING = 8'hBE;

  typedef enum logic [2:0] {
    PH_DROP = 3'b001,
    PH_HDR  = 3'b010,
    PH_PAY  = 3'b100
  } phase_t;

  // Byte event (payload, header or error) handed from the parser to the timestamp stage.
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        end_of_pes;
    logic        has_pts;
    logic [32:0] pts;
    logic [32:0] dts;
    logic        syntax_bad;
    logic [1:0]  error_code;
    logic        sync_lost;
    logic        truncated;
  } event_t;

  // Result item in port field order.
  typedef struct packed {
    logic        truncated_header;
    logic        sync_lost;
    logic [1:0]  error_code;
    logic        timestamp_syntax_bad;
    logic        delay_invalid;
    logic [31:0] pts_delay_ticks;
    logic [41:0] dts_ticks;
    logic        has_timestamp;
    logic        end_of_pes;
    logic [7:0]  payload_byte;
    logic [1:0]  result_kind;
  } result_t;

  function automatic logic header_only_id(input logic [7:0] id);
    return id == 8'hBC || id == 8'hBF || id == 8'hF0 || id == 8'hF1 ||
           id == 8'hFF || id == 8'hF2 || id == 8'hF8;
  endfunction
endpackage

// ----- design/pes_header_stripper_unit.sv -----
// Top level of the PES header stripper.
// PES header stripper: takes one PES byte per request on in_ (tdata = data_byte,
// tuser = unit_start) and returns at most one result per byte on out_.
// A byte that opens a PES start chunk restarts header parsing. The six-byte
// header and the optional header are checked; one header result (kind 1)
// carries scaled DTS and PTS-DTS delay, errors give kind 2 and drop the
// stream until the next start. Payload bytes then pass as kind 0, the byte
// that reaches the declared PES size marked with end_of_pes.
// Pipeline: parser state advances at the accepting edge, which also loads the
// event register; the scaled result then moves into the output register once
// that register is empty or taken.
// Throughput: one byte per cycle unless the receiver stalls a full pipeline, set
// by the byte state machine which updates once per accepted byte.
// Reset (rst_n low, synchronous) drops sync, restores tick_multiplier 300 and
// the delay limit 1620000000, and empties both stages.
// When the receiver stalls the output register holds its request and an empty
// event stage can still fill; in_tready falls only while both stages hold a
// request and out_tready is low.
// Configuration writes are always accepted (cfg_ready is tied high).
module pes_header_stripper_unit
  import phs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] data_byte
  input  logic         in_tuser,    // [0] unit_start
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] result_kind, [9:2] payload_byte, [10] end_of_pes, [11] has_timestamp,
  // [53:12] dts_ticks, [85:54] pts_delay_ticks, [86] delay_invalid,
  // [87] timestamp_syntax_bad, [89:88] error_code, [90] sync_lost,
  // [91] truncated_header, [95:92] zero
  output logic [95:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  logic [9:0]  tick_mult_r;
  logic [31:0] delay_limit_r;
  event_t      evt_c, evt_ld, evt_r;
  result_t     res_c, res_r;
  logic        out_vld_r;
  logic        adv_out, adv_evt, accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_mult_r   <= 10'd300;
      delay_limit_r <= 32'd1620000000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TICK_MULT:   tick_mult_r   <= cfg_data[9:0];
        CFG_DELAY_LIMIT: delay_limit_r <= cfg_data;
      endcase
    end
  end

  // Stage advance: output slot frees when empty or taken.
  assign adv_out   = !out_vld_r || out_tready;
  assign adv_evt   = !evt_r.valid || adv_out;
  assign in_tready = adv_evt;
  assign accept    = in_tvalid && in_tready;

  phs_parser u_parser (
    .clk(clk), .rst_n(rst_n), .en(accept),
    .data_byte(in_tdata), .unit_start(in_tuser), .evt(evt_c)
  );

  // Keep the event only when its byte is actually taken.
  always_comb begin
    evt_ld = evt_c;
    evt_ld.valid = accept && evt_c.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) evt_r <= '0;
    else if (adv_evt) evt_r <= evt_ld;
  end

  phs_scaler u_scaler (
    .evt(evt_r), .tick_mult(tick_mult_r), .delay_limit(delay_limit_r), .res(res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv_out) out_vld_r <= evt_r.valid;
  end
  always_ff @(posedge clk) begin
    if (adv_out) res_r <= res_c;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, res_r};
endmodule

// ----- design/phs_parser.sv -----
// Byte-level PES header state machine.
module phs_parser
  import phs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] data_byte,
  input  logic       unit_start,
  output event_t     evt
);
  phase_t      phase_r, phase_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [16:0] size_r, size_nxt;
  logic [7:0]  sid_r, sid_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [7:0]  hlen_r, hlen_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [32:0] pts_r, pts_nxt;
  logic [32:0] dts_r, dts_nxt;
  logic        mok_r, mok_nxt;
  logic        sync_r, sync_nxt;
  logic        sok_r, sok_nxt;
  logic        trunc_r, trunc_nxt;

  always_comb begin
    logic [16:0] i;
    logic [16:0] off;
    logic [15:0] dl;
    logic        hdr_done;
    logic [2:0]  k;
    phase_nxt = phase_r;  cnt_nxt = cnt_r;   size_nxt = size_r;
    sid_nxt = sid_r;      dlen_nxt = dlen_r; hlen_nxt = hlen_r;
    flags_nxt = flags_r;  pts_nxt = pts_r;   dts_nxt = dts_r;
    mok_nxt = mok_r;      sync_nxt = sync_r; sok_nxt = sok_r;
    trunc_nxt = trunc_r;
    evt = '0;
    hdr_done = 1'b0;
    k = '0;
    dl = '0;
    if (unit_start) begin
      if (phase_r == PH_HDR) trunc_nxt = 1'b1;
      phase_nxt = PH_HDR;
      cnt_nxt = '0; size_nxt = '0; sid_nxt = '0; dlen_nxt = '0; hlen_nxt = '0;
      flags_nxt = '0; pts_nxt = '0; dts_nxt = '0; mok_nxt = 1'b1; sok_nxt = 1'b1;
    end
    i = cnt_nxt;
    off = i - 17'd9;
    if (phase_nxt == PH_HDR) begin
      cnt_nxt = i + 17'd1;
      if (i < 17'd3) begin
        if (data_byte != ((i == 17'd2) ? 8'd1 : 8'd0)) sok_nxt = 1'b0;
      end else if (i == 17'd3) begin
        sid_nxt = data_byte;
      end else if (i == 17'd4) begin
        dlen_nxt = {data_byte, 8'd0};
      end else if (i == 17'd5) begin
        dl = {dlen_nxt[15:8], data_byte};
        dlen_nxt = dl;
        if (!sok_nxt) begin
          evt.valid = 1'b1; evt.kind = KIND_ERROR; evt.error_code = ERR_START;
        end else if (sid_nxt == SID_PADDING) begin
          phase_nxt = PH_DROP;
        end else begin
          size_nxt = (dl != 16'd0) ? ({1'b0, dl} + 17'd6) : 17'd0;
          if (header_only_id(sid_nxt)) hdr_done = 1'b1;
          else if (dl != 16'd0 && dl < 16'd3) begin
            evt.valid = 1'b1; evt.kind = KIND_ERROR; evt.error_code = ERR_LENGTH;
          end
        end
      end else if (i == 17'd6) begin
        if ((data_byte & 8'hC0) != 8'h80) begin
          evt.valid = 1'b1; evt.kind = KIND_ERROR; evt.error_code = ERR_MARKER;
        end
      end else if (i == 17'd7) begin
        flags_nxt = data_byte[7:6];
      end else begin
        if (i == 17'd8) begin
          hlen_nxt = data_byte;
          if ((dlen_nxt != 16'd0 && ({8'd0, data_byte} + 16'd3) > dlen_nxt) ||
              (flags_nxt[1] && data_byte < 8'd5) ||
              (flags_nxt == 2'b11 && data_byte < 8'd10)) begin
            evt.valid = 1'b1; evt.kind = KIND_ERROR; evt.error_code = ERR_HDRLEN;
          end
        end else if (flags_nxt[1] && off < 17'd5) begin
          k = off[2:0];
          unique case (k)
            3'd0:      pts_nxt = {30'd0, data_byte[3:1]};
            3'd1, 3'd3: pts_nxt = {pts_nxt[24:0], data_byte};
            default:   pts_nxt = {pts_nxt[25:0], data_byte[7:1]};
          endcase
          if (k == 3'd0 ? ((data_byte & 8'hE1) != 8'h21)
                        : ((k == 3'd2 || k == 3'd4) && !data_byte[0]))
            mok_nxt = 1'b0;
        end else if (flags_nxt == 2'b11 && off >= 17'd5 && off < 17'd10) begin
          k = 3'(off - 17'd5);
          unique case (k)
            3'd0:      dts_nxt = {30'd0, data_byte[3:1]};
            3'd1, 3'd3: dts_nxt = {dts_nxt[24:0], data_byte};
            default:   dts_nxt = {dts_nxt[25:0], data_byte[7:1]};
          endcase
          if ((k == 3'd0 || k == 3'd2 || k == 3'd4) && !data_byte[0]) mok_nxt = 1'b0;
        end
        if (!evt.valid && cnt_nxt >= (17'd9 + {9'd0, hlen_nxt})) hdr_done = 1'b1;
      end
      if (evt.valid) begin
        evt.sync_lost = sync_r;
        evt.truncated = trunc_nxt;
        trunc_nxt = 1'b0;
        sync_nxt = 1'b0;
        phase_nxt = PH_DROP;
      end else if (hdr_done) begin
        evt.valid = 1'b1;
        evt.kind = KIND_HEADER;
        evt.has_pts = flags_nxt[1];
        evt.pts = pts_nxt;
        evt.dts = (flags_nxt == 2'b11) ? dts_nxt : pts_nxt;
        evt.syntax_bad = flags_nxt[1] && !mok_nxt;
        evt.truncated = trunc_nxt;
        trunc_nxt = 1'b0;
        sync_nxt = 1'b1;
        phase_nxt = PH_PAY;
        if (size_nxt != 17'd0 && cnt_nxt == size_nxt) begin
          evt.end_of_pes = 1'b1;
          cnt_nxt = '0;
          size_nxt = '0;
        end
      end
    end else if (phase_nxt == PH_PAY) begin
      evt.valid = 1'b1;
      evt.kind = KIND_PAYLOAD;
      evt.payload_byte = data_byte;
      if (size_nxt != 17'd0) begin
        cnt_nxt = i + 17'd1;
        if (cnt_nxt == size_nxt) begin
          evt.end_of_pes = 1'b1;
          cnt_nxt = '0;
          size_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DROP; cnt_r <= '0; size_r <= '0; sid_r <= '0; dlen_r <= '0;
      hlen_r <= '0; flags_r <= '0; pts_r <= '0; dts_r <= '0; mok_r <= 1'b1;
      sync_r <= 1'b0; sok_r <= 1'b1; trunc_r <= 1'b0;
    end else if (en) begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; size_r <= size_nxt; sid_r <= sid_nxt;
      dlen_r <= dlen_nxt; hlen_r <= hlen_nxt; flags_r <= flags_nxt;
      pts_r <= pts_nxt; dts_r <= dts_nxt; mok_r <= mok_nxt; sync_r <= sync_nxt;
      sok_r <= sok_nxt; trunc_r <= trunc_nxt;
    end
  end
endmodule

// ----- design/phs_scaler.sv -----
// Timestamp scaling and delay limit check of a registered event.
module phs_scaler
  import phs_pkg::*;
(
  input  event_t      evt,
  input  logic [9:0]  tick_mult,
  input  logic [31:0] delay_limit,
  output result_t     res
);
  logic [32:0] delta;
  logic [42:0] delay;
  logic [42:0] dts_scaled;

  assign delta      = evt.pts - evt.dts;
  assign delay      = delta * tick_mult;
  assign dts_scaled = evt.dts * tick_mult;

  always_comb begin
    res = '0;
    res.result_kind      = evt.kind;
    res.payload_byte     = evt.payload_byte;
    res.end_of_pes       = evt.end_of_pes;
    res.error_code       = evt.error_code;
    res.sync_lost        = evt.sync_lost;
    res.truncated_header = evt.truncated;
    if (evt.has_pts) begin
      res.has_timestamp        = 1'b1;
      res.dts_ticks            = dts_scaled[41:0];
      res.timestamp_syntax_bad = evt.syntax_bad;
      if (delay > {11'd0, delay_limit}) res.delay_invalid = 1'b1;
      else res.pts_delay_ticks = delay[31:0];
    end
  end
endmodule

// ----- design/phs_checker.sv -----
// Port-level checker for the PES header stripper, bound to the top level.
`include "pes_header_stripper_unit_defines.svh"
module phs_checker
  import phs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata
);
  `PHS_ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `PHS_ASSERT_ALWAYS(a_kind, clk, rst_n, !out_tvalid || out_tdata[1:0] != 2'd3, "bad result kind")
  `PHS_ASSERT_ALWAYS(a_pay_clean, clk, rst_n, !out_tvalid || out_tdata[1:0] != KIND_PAYLOAD || out_tdata[95:11] == '0, "payload result carries header fields")
  `PHS_ASSERT_ALWAYS(a_ready, clk, rst_n, in_tready || (out_tvalid && !out_tready), "input blocked without a stalled result")
  `PHS_ASSERT_NEXT(a_empty, clk, rst_n, !out_tvalid && !in_tvalid, in_tready, "input blocked while empty")
endmodule

bind pes_header_stripper_unit phs_checker u_phs_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

// ----- test/tb_pes_header_stripper_unit.sv -----
// Self-checking testbench of the PES header stripper with its own header and timestamp model.
module tb_pes_header_stripper_unit;
  import phs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_TICK_MULT;
  logic [31:0] cfg_data = '0;

  pes_header_stripper_unit uut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the parser state and of the two registers.
  phase_t      ph;
  logic [16:0] cnt, psize;
  logic [7:0]  sid, hxl;
  logic [15:0] dlen;
  logic [1:0]  pflags;
  logic [63:0] ptsv, dtsv;
  bit          mark_ok, in_sync, start_ok, trunc_seen;
  logic [9:0]  tick_mult;
  logic [31:0] delay_limit;

  result_t expected_results[$];
  int          fail_count = 0;
  int          cycles = 0;
  int          burst_left = 0;
  bit          no_gaps = 0;
  int          hold_cycles = 0;
  int          stall_pct = 0;
  int          sent_bytes = 0;

  // Packet under construction: bytes and their unit-start marks.
  logic [7:0]  pkt_data[$];
  bit          pkt_start[$];

  function automatic bit is_bare_id(input logic [7:0] id);
    unique case (id)
      8'hBC, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic model_reset();
    ph = PH_DROP; cnt = '0; psize = '0; sid = '0; dlen = '0; hxl = '0; pflags = '0;
    ptsv = '0; dtsv = '0; mark_ok = 1; in_sync = 0; start_ok = 1; trunc_seen = 0;
    tick_mult = 10'd300; delay_limit = 32'd1620000000;
  endtask

  task automatic header_error(input logic [1:0] code, output result_t r);
    r = '0;
    r.result_kind = KIND_ERROR;
    r.error_code = code;
    r.sync_lost = in_sync;
    r.truncated_header = trunc_seen;
    trunc_seen = 0; in_sync = 0; ph = PH_DROP;
  endtask

  task automatic header_done(output result_t r);
    logic [32:0] p, d, diff;
    logic [63:0] delay, dscaled;
    r = '0;
    r.result_kind = KIND_HEADER;
    if (pflags[1]) begin
      p = ptsv[32:0];
      d = (pflags == 2'b11) ? dtsv[32:0] : p;
      diff = p - d;
      delay = 64'(diff) * 64'(tick_mult);
      dscaled = 64'(d) * 64'(tick_mult);
      r.has_timestamp = 1;
      r.dts_ticks = dscaled[41:0];
      if (delay > 64'(delay_limit)) r.delay_invalid = 1;
      else r.pts_delay_ticks = delay[31:0];
      r.timestamp_syntax_bad = !mark_ok;
    end
    r.truncated_header = trunc_seen;
    trunc_seen = 0; in_sync = 1; ph = PH_PAY;
    if (psize != 0 && cnt == psize) begin
      r.end_of_pes = 1; cnt = '0; psize = '0;
    end
  endtask

  // Walk one header byte; got is set when it closes the header one way or the other.
  task automatic header_step(input logic [7:0] b, output bit got, output result_t r);
    logic [16:0] i, off;
    int k;
    got = 0; r = '0;
    i = cnt;
    cnt = cnt + 1;
    if (i < 3) begin
      if (b != ((i == 2) ? 8'd1 : 8'd0)) start_ok = 0;
    end else if (i == 3) begin
      sid = b;
    end else if (i == 4) begin
      dlen = {b, 8'h00};
    end else if (i == 5) begin
      dlen[7:0] = b;
      if (!start_ok) begin
        header_error(ERR_START, r); got = 1;
      end else if (sid == SID_PADDING) begin
        ph = PH_DROP;
      end else begin
        psize = (dlen != 0) ? 17'(dlen) + 17'd6 : 17'd0;
        if (is_bare_id(sid)) begin
          header_done(r); got = 1;
        end else if (dlen != 0 && dlen < 3) begin
          header_error(ERR_LENGTH, r); got = 1;
        end
      end
    end else if (i == 6) begin
      if (b[7:6] != 2'b10) begin
        header_error(ERR_MARKER, r); got = 1;
      end
    end else if (i == 7) begin
      pflags = b[7:6];
    end else begin
      if (i == 8) begin
        hxl = b;
        if ((dlen != 0 && 17'(b) + 17'd3 > 17'(dlen)) || (pflags[1] && b < 5) ||
            (pflags == 2'b11 && b < 10)) begin
          header_error(ERR_HDRLEN, r); got = 1;
        end
      end else begin
        off = i - 17'd9;
        if (pflags[1] && off < 5) begin
          k = int'(off);
          ptsv = (k == 0) ? 64'(b[3:1]) : (k == 1 || k == 3) ? {ptsv[55:0], b} :
                 {ptsv[56:0], b[7:1]};
          if (k == 0 ? ((b & 8'hE1) != 8'h21) : ((k == 2 || k == 4) && !b[0])) mark_ok = 0;
        end else if (pflags == 2'b11 && off >= 5 && off < 10) begin
          k = int'(off) - 5;
          dtsv = (k == 0) ? 64'(b[3:1]) : (k == 1 || k == 3) ? {dtsv[55:0], b} :
                 {dtsv[56:0], b[7:1]};
          if ((k == 0 || k == 2 || k == 4) && !b[0]) mark_ok = 0;
        end
      end
      if (!got && cnt >= 17'd9 + 17'(hxl)) begin
        header_done(r); got = 1;
      end
    end
  endtask

  // Predict the result, if any, that one accepted byte causes.
  task automatic predict_byte(input logic [7:0] b, input bit st, output bit got,
                              output result_t r);
    got = 0; r = '0;
    if (st) begin
      if (ph == PH_HDR) trunc_seen = 1;
      ph = PH_HDR; cnt = '0; psize = '0; sid = '0; dlen = '0; hxl = '0; pflags = '0;
      ptsv = '0; dtsv = '0; mark_ok = 1; start_ok = 1;
    end
    if (ph == PH_HDR) begin
      header_step(b, got, r);
    end else if (ph == PH_PAY) begin
      got = 1;
      r.result_kind = KIND_PAYLOAD;
      r.payload_byte = b;
      if (psize != 0) begin
        cnt = cnt + 1;
        if (cnt == psize) begin
          r.end_of_pes = 1; cnt = '0; psize = '0;
        end
      end
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got 0x%0h expected 0x%0h at cycle %0d", what, got, exp, cycles);
    fail_count++;
  endtask

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t g, e;
    if (rst_n && out_tvalid && out_tready) begin
      g = out_tdata[91:0];
      if (expected_results.size() == 0) begin
        report("unexpected result", out_tdata[63:0], 64'd0);
      end else begin
        e = expected_results.pop_front();
        if (g.result_kind != e.result_kind)
          report("result_kind", 64'(g.result_kind), 64'(e.result_kind));
        if (g.payload_byte != e.payload_byte)
          report("payload_byte", 64'(g.payload_byte), 64'(e.payload_byte));
        if (g.end_of_pes != e.end_of_pes)
          report("end_of_pes", 64'(g.end_of_pes), 64'(e.end_of_pes));
        if (g.has_timestamp != e.has_timestamp)
          report("has_timestamp", 64'(g.has_timestamp), 64'(e.has_timestamp));
        if (g.dts_ticks != e.dts_ticks)
          report("dts_ticks", 64'(g.dts_ticks), 64'(e.dts_ticks));
        if (g.pts_delay_ticks != e.pts_delay_ticks)
          report("pts_delay_ticks", 64'(g.pts_delay_ticks), 64'(e.pts_delay_ticks));
        if (g.delay_invalid != e.delay_invalid)
          report("delay_invalid", 64'(g.delay_invalid), 64'(e.delay_invalid));
        if (g.timestamp_syntax_bad != e.timestamp_syntax_bad)
          report("timestamp_syntax_bad", 64'(g.timestamp_syntax_bad),
                 64'(e.timestamp_syntax_bad));
        if (g.error_code != e.error_code)
          report("error_code", 64'(g.error_code), 64'(e.error_code));
        if (g.sync_lost != e.sync_lost)
          report("sync_lost", 64'(g.sync_lost), 64'(e.sync_lost));
        if (g.truncated_header != e.truncated_header)
          report("truncated_header", 64'(g.truncated_header), 64'(e.truncated_header));
        if (out_tdata[95:92] != 4'd0) report("pad bits", 64'(out_tdata[95:92]), 64'd0);
      end
    end
  end

  // Receiver: a long hold when requested, otherwise a stall rate that changes now and then.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      if (cycles % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct <= 0;
          1: stall_pct <= 30;
          default: stall_pct <= 70;
        endcase
      end
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pes_header_stripper_unit regression: fail");
      $finish;
    end
  end

  // Send one byte; called at a falling edge, returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input bit st);
    bit got;
    result_t r;
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= st;
    do @(posedge clk); while (!in_tready);
    predict_byte(b, st, got, r);
    if (got) expected_results.push_back(r);
    sent_bytes++;
    @(negedge clk);
  endtask

  task automatic send_packet();
    while (pkt_data.size() > 0) send_byte(pkt_data.pop_front(), pkt_start.pop_front());
  endtask

  // Assemble a PES packet; bounded selects a declared length, bad_ts breaks a timestamp byte.
  task automatic build_pes(input logic [7:0] id, input bit bounded, input logic [1:0] pf,
                           input int extra, input int npay, input bit bad_ts,
                           input logic [32:0] pts, input logic [32:0] dts);
    int hl, base, n;
    logic [15:0] len;
    logic [7:0] ts[10];
    bit bare;
    bare = is_bare_id(id) || id == SID_PADDING;
    hl = ((pf == 2'b11) ? 10 : pf[1] ? 5 : 0) + extra;
    len = bare ? 16'(npay) : 16'(3 + hl + npay);
    if (!bounded) len = '0;
    pkt_data.push_back(8'h00); pkt_start.push_back(1);
    pkt_data.push_back(8'h00); pkt_start.push_back(0);
    pkt_data.push_back(8'h01); pkt_start.push_back(0);
    pkt_data.push_back(id);    pkt_start.push_back(0);
    pkt_data.push_back(len[15:8]); pkt_start.push_back(0);
    pkt_data.push_back(len[7:0]);  pkt_start.push_back(0);
    if (!bare) begin
      pkt_data.push_back(8'h80 | 8'($urandom_range(0, 63))); pkt_start.push_back(0);
      pkt_data.push_back({pf, 6'($urandom_range(0, 63))});   pkt_start.push_back(0);
      pkt_data.push_back(8'(hl)); pkt_start.push_back(0);
      ts[0] = {3'b001, pf == 2'b11, pts[32:30], 1'b1};
      ts[1] = pts[29:22]; ts[2] = {pts[21:15], 1'b1};
      ts[3] = pts[14:7];  ts[4] = {pts[6:0], 1'b1};
      ts[5] = {4'b0001, dts[32:30], 1'b1};
      ts[6] = dts[29:22]; ts[7] = {dts[21:15], 1'b1};
      ts[8] = dts[14:7];  ts[9] = {dts[6:0], 1'b1};
      n = (pf == 2'b11) ? 10 : pf[1] ? 5 : 0;
      if (bad_ts && n > 0) begin
        base = $urandom_range(0, n - 1);
        ts[base] = ts[base] ^ ((base % 5 == 0) ? 8'h21 : 8'h01);
      end
      for (int j = 0; j < n; j++) begin
        pkt_data.push_back(ts[j]); pkt_start.push_back(0);
      end
      for (int j = 0; j < extra; j++) begin
        pkt_data.push_back(8'($urandom)); pkt_start.push_back(0);
      end
    end
    for (int j = 0; j < npay; j++) begin
      pkt_data.push_back(8'($urandom)); pkt_start.push_back(0);
    end
  endtask

  function automatic logic [32:0] rand_ts();
    return {1'($urandom), 32'($urandom)};
  endfunction

  // Let the last results out, then a margin for bytes that cause none.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_TICK_MULT) tick_mult = val[9:0];
    else delay_limit = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Well-formed headers: timestamp flag variants, bare ids, padding, end at header end.
  task automatic test_headers();
    build_pes(8'hE0, 1, 2'b11, 0, 2, 0, 33'h1FFFFFFFF, 33'h0);
    build_pes(8'hC0, 0, 2'b10, 0, 1, 0, rand_ts(), 33'h0);
    build_pes(8'hE0, 1, 2'b01, 0, 0, 0, 33'h0, 33'h0);
    build_pes(8'hBC, 1, 2'b00, 0, 1, 0, 33'h0, 33'h0);
    build_pes(SID_PADDING, 1, 2'b00, 0, 2, 0, 33'h0, 33'h0);
    send_packet();
    drain();
  endtask

  // Each header error, a truncated header, loss of sync and a corrupted timestamp byte.
  task automatic test_errors();
    build_pes(8'hE0, 1, 2'b00, 0, 0, 0, 33'h0, 33'h0);
    pkt_data[1] = 8'h55;
    send_packet();
    pkt_data = '{8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h01};
    pkt_start = '{1, 0, 0, 0, 0, 0};
    send_packet();
    build_pes(8'hE0, 0, 2'b00, 0, 0, 0, 33'h0, 33'h0);
    pkt_data[6] = 8'h40;
    send_packet();
    build_pes(8'hE0, 0, 2'b00, 0, 0, 0, 33'h0, 33'h0);
    pkt_data[7] = 8'hC0;
    pkt_data[8] = 8'h04;
    send_packet();
    pkt_data = '{8'h00, 8'h00, 8'h01, 8'hE0};
    pkt_start = '{1, 0, 0, 0};
    send_packet();
    build_pes(8'hE0, 1, 2'b10, 0, 1, 1, rand_ts(), 33'h0);
    send_packet();
    drain();
  endtask

  // Random traffic: mostly whole packets, the rest noise and broken packets.
  task automatic test_random(input int nbytes);
    int stop, sel, cut;
    logic [7:0] id;
    stop = sent_bytes + nbytes;
    while (sent_bytes < stop) begin
      no_gaps = ($urandom_range(0, 7) == 0);
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: id = 8'hBC;
        1: id = 8'hF8;
        2: id = SID_PADDING;
        default: id = 8'($urandom_range(8'hC0, 8'hEF));
      endcase
      build_pes(id, $urandom_range(0, 4) != 0, 2'($urandom), $urandom_range(0, 3),
                $urandom_range(0, 12), $urandom_range(0, 5) == 0, rand_ts(), rand_ts());
      if (sel < 70) begin
        if ($urandom_range(0, 3) == 0) begin
          pkt_data.push_back(8'($urandom)); pkt_start.push_back(0);
        end
      end else if (sel < 85) begin
        cut = $urandom_range(1, pkt_data.size());
        while (pkt_data.size() > cut) begin
          void'(pkt_data.pop_back()); void'(pkt_start.pop_back());
        end
      end else if (sel < 93) begin
        pkt_data[$urandom_range(0, pkt_data.size() - 1)] = 8'($urandom);
      end else begin
        for (int j = 0; j < 6; j++) begin
          pkt_data.push_back(8'($urandom)); pkt_start.push_back($urandom_range(0, 5) == 0);
        end
      end
      send_packet();
    end
    no_gaps = 0;
    drain();
  endtask

  // Hold off the receiver while a long payload keeps coming, so the input stalls.
  task automatic test_backpressure();
    hold_cycles = 300;
    no_gaps = 1;
    build_pes(8'hE0, 1, 2'b11, 0, 40, 0, rand_ts(), rand_ts());
    send_packet();
    no_gaps = 0;
    drain();
  endtask

  initial begin
    model_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_headers();
    test_errors();
    write_reg(CFG_TICK_MULT, 32'd1);
    write_reg(CFG_DELAY_LIMIT, 32'd0);
    test_random(75);
    write_reg(CFG_TICK_MULT, 32'd1023);
    write_reg(CFG_DELAY_LIMIT, 32'hFFFFFFFF);
    test_random(75);
    test_backpressure();
    write_reg(CFG_TICK_MULT, 32'($urandom_range(1, 1023)));
    write_reg(CFG_DELAY_LIMIT, $urandom);
    test_random(80);
    write_reg(CFG_TICK_MULT, 32'd300);
    write_reg(CFG_DELAY_LIMIT, 32'd1620000000);
    test_random(80);
    if (fail_count == 0) begin
      $display("pes_header_stripper_unit regression: pass");
    end else begin
      $display("pes_header_stripper_unit regression: fail");
    end
    $finish;
  end
endmodule

// ----- pes_header_stripper_unit.f -----
+incdir+design
design/phs_pkg.sv
design/phs_parser.sv
design/phs_scaler.sv
design/pes_header_stripper_unit.sv
design/phs_checker.sv
test/tb_pes_header_stripper_unit.sv
